>>> hdl/mpfd_pkg.sv
// Shared types, constants and address helpers for the page-organized
// monochrome frame store with per-page dirty bits. No dependencies.
`default_nettype none

package mpfd_pkg;

    // Display geometry.
    localparam int DISPLAY_WIDTH = 128;
    localparam int PAGE_COUNT    = 8;
    localparam int ROWS_TOTAL    = PAGE_COUNT * 8;

    // Derived widths. The column field is rounded up to a power of two so that a
    // byte address is simply {page, column}.
    localparam int PAGE_W    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int COL_W     = $clog2(DISPLAY_WIDTH);
    localparam int ADDR_W    = PAGE_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // Byte constants.
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [2:0] ROW_MASK  = 3'h7;

    // Item kinds carried on the input tuser.
    typedef enum logic [2:0] {
        K_PIXEL = 3'd0,
        K_FILL  = 3'd1,
        K_MARK  = 3'd2,
        K_TAKE  = 3'd3,
        K_READ  = 3'd4
    } t_kind;

    // Result word, clipped in the lowest bit.
    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] page_index;
        logic       page_found;
        logic       clipped;
    } t_result;

    // Commands from the sequencer to the dirty-page tracker.
    typedef struct packed {
        logic              set_one;
        logic [PAGE_W-1:0] set_page;
        logic              set_all;
        logic              scan_start;
    } t_dirty_cmd;

    // Scan status from the dirty-page tracker.
    typedef struct packed {
        logic              done;
        logic              found;
        logic [PAGE_W-1:0] page;
    } t_scan_status;

    // Byte address of a page and column; both arguments are already in range.
    function automatic logic [ADDR_W-1:0] mk_addr(input logic [7:0] page,
                                                  input logic [7:0] column);
        mk_addr = {page[PAGE_W-1:0], column[COL_W-1:0]};
    endfunction

    // Low three bits of a page number, as reported in the result.
    function automatic logic [2:0] page_to_idx(input logic [PAGE_W-1:0] page);
        logic [7:0] wide;
        wide = 8'(page);
        page_to_idx = wide[2:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/mpfd_ram.sv
// Generic simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No dependencies.
`default_nettype none

module mpfd_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [1 << ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/mpfd_dirty.sv
// Dirty-page tracker: one dirty bit per page and the round-robin flush
// pointer, scanned one page per cycle. Depends on mpfd_pkg.
`default_nettype none

module mpfd_dirty
    import mpfd_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_dirty_cmd   i_cmd,
    output      t_scan_status o_status
);

    logic [PAGE_COUNT-1:0] r_dirty;
    logic [PAGE_COUNT-1:0] n_dirty;
    logic [PAGE_W-1:0]     r_ptr;
    logic [PAGE_W-1:0]     n_ptr;
    logic [PAGE_W-1:0]     r_count;
    logic [PAGE_W-1:0]     n_count;
    logic                  r_busy;
    logic                  n_busy;
    logic                  hit;
    logic                  last;
    logic [PAGE_W-1:0]     ptr_inc;

    assign hit     = r_dirty[r_ptr];
    assign last    = (r_count == PAGE_W'(PAGE_COUNT - 1));
    assign ptr_inc = (r_ptr == PAGE_W'(PAGE_COUNT - 1)) ? '0 : r_ptr + 1'b1;

    always_comb begin
        n_dirty = r_dirty;
        n_ptr   = r_ptr;
        n_count = r_count;
        n_busy  = r_busy;
        if (i_cmd.set_all) begin
            n_dirty = '1;
        end
        if (i_cmd.set_one) begin
            n_dirty[i_cmd.set_page] = 1'b1;
        end
        if (i_cmd.scan_start) begin
            n_busy  = 1'b1;
            n_count = '0;
        end
        // Each scan step moves the pointer; a hit clears that page and stops.
        if (r_busy) begin
            n_ptr   = ptr_inc;
            n_count = r_count + 1'b1;
            if (hit) begin
                n_dirty[r_ptr] = 1'b0;
                n_busy         = 1'b0;
            end else if (last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= '0;
            r_ptr   <= '0;
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_dirty <= n_dirty;
            r_ptr   <= n_ptr;
            r_count <= n_count;
            r_busy  <= n_busy;
        end
    end

    assign o_status.done  = r_busy && (hit || last);
    assign o_status.found = r_busy && hit;
    assign o_status.page  = r_ptr;

endmodule

`default_nettype wire

>>> hdl/mono_page_framebuffer_dirty.sv
// Top level of the page-organized monochrome frame store: item sequencer,
// output register, frame RAM and dirty tracker. Depends on mpfd_pkg,
// mpfd_ram and mpfd_dirty.
`default_nettype none

// The frame is held as PAGE_COUNT pages of DISPLAY_WIDTH bytes in one
// synchronous RAM; bit n of a byte is row n of its page. Each accepted word
// gives exactly one result word. A pixel write is a read-modify-write of one
// byte, fetched in S_IDLE and written back in S_RMW; a byte read likewise
// goes through S_READ, because the RAM's read data is registered. A clipped
// pixel, mark-all-dirty, an out-of-range read or an unknown kind finishes
// straight from S_IDLE. Take-next-dirty-page walks the dirty bits one page
// per cycle from the flush pointer. Fill rewrites every RAM location, one per
// cycle. After reset the block runs the same pass to zero the RAM and accepts
// no word until that pass is done. Items are handled one at a time; a
// finished result waits in the output register while the next word is
// accepted.
module mono_page_framebuffer_dirty
    import mpfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // [7:0] pixel_x, [15:8] pixel_y, [16] color, [19:17] read_page,
    // [26:20] read_column, [31:27] zero
    input  wire logic [31:0] s_axis_tdata,
    // [2:0] kind
    input  wire logic [2:0]  s_axis_tuser,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] clipped, [1] page_found, [4:2] page_index, [12:5] read_data,
    // [15:13] zero
    output      logic [15:0] m_axis_tdata
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RMW   = 6'b000010,
        S_READ  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_CLEAR = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    // Input fields.
    logic [2:0] in_kind;
    logic [7:0] in_px;
    logic [7:0] in_py;
    logic       in_color;
    logic [2:0] in_rpage;
    logic [6:0] in_rcol;

    assign in_kind  = s_axis_tuser;
    assign in_px    = s_axis_tdata[7:0];
    assign in_py    = s_axis_tdata[15:8];
    assign in_color = s_axis_tdata[16];
    assign in_rpage = s_axis_tdata[19:17];
    assign in_rcol  = s_axis_tdata[26:20];

    t_state            r_state,        n_state;
    logic [ADDR_W-1:0] r_addr,         n_addr;
    logic [7:0]        r_mask,         n_mask;
    logic              r_color,        n_color;
    logic [PAGE_W-1:0] r_page,         n_page;
    logic [7:0]        r_fill_byte,    n_fill_byte;
    logic              r_fill_pending, n_fill_pending;
    t_result           r_res,          n_res;
    logic              r_out_valid,    n_out_valid;
    t_result           r_out,          n_out;

    logic              accept;
    logic              out_free;
    logic              pixel_ok;
    logic              read_ok;
    logic              finish;
    t_result           res;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    t_dirty_cmd        dirty_cmd;
    t_scan_status      scan;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign pixel_ok = ({1'b0, in_px} < 9'(DISPLAY_WIDTH)) &&
                      ({1'b0, in_py} < 9'(ROWS_TOTAL));
    assign read_ok  = (6'(in_rpage) < 6'(PAGE_COUNT)) &&
                      (9'(in_rcol) < 9'(DISPLAY_WIDTH));

    always_comb begin
        n_state        = r_state;
        n_addr         = r_addr;
        n_mask         = r_mask;
        n_color        = r_color;
        n_page         = r_page;
        n_fill_byte    = r_fill_byte;
        n_fill_pending = r_fill_pending;
        n_res          = r_res;
        n_out          = r_out;
        n_out_valid    = r_out_valid && !m_axis_tready;
        finish         = 1'b0;
        res            = '0;
        ram_we         = 1'b0;
        ram_waddr      = r_addr;
        ram_wdata      = r_fill_byte;
        ram_re         = 1'b0;
        ram_raddr      = mk_addr(8'(in_rpage), 8'(in_rcol));
        dirty_cmd      = '0;
        dirty_cmd.set_page = r_page;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (in_kind)
                        K_PIXEL: begin
                            if (pixel_ok) begin
                                // Fetch the byte that holds this pixel.
                                ram_re    = 1'b1;
                                ram_raddr = mk_addr({3'b000, in_py[7:3]}, in_px);
                                n_addr    = ram_raddr;
                                n_mask    = 8'h01 << (in_py[2:0] & ROW_MASK);
                                n_color   = in_color;
                                n_page    = in_py[PAGE_W+2:3];
                                n_state   = S_RMW;
                            end else begin
                                finish      = 1'b1;
                                res.clipped = 1'b1;
                            end
                        end
                        K_FILL: begin
                            dirty_cmd.set_all = 1'b1;
                            n_fill_byte       = in_color ? BYTE_ONES : BYTE_ZERO;
                            n_fill_pending    = 1'b1;
                            n_addr            = '0;
                            n_state           = S_CLEAR;
                        end
                        K_MARK: begin
                            dirty_cmd.set_all = 1'b1;
                            finish            = 1'b1;
                        end
                        K_TAKE: begin
                            dirty_cmd.scan_start = 1'b1;
                            n_state              = S_SCAN;
                        end
                        K_READ: begin
                            if (read_ok) begin
                                ram_re  = 1'b1;
                                n_state = S_READ;
                            end else begin
                                finish = 1'b1;
                            end
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_RMW: begin
                // Only one access is ever in flight, so no forwarding is needed.
                ram_we            = 1'b1;
                ram_waddr         = r_addr;
                ram_wdata         = r_color ? (ram_rdata | r_mask) : (ram_rdata & ~r_mask);
                dirty_cmd.set_one = 1'b1;
                finish            = 1'b1;
            end
            S_READ: begin
                res.read_data = ram_rdata;
                finish        = 1'b1;
            end
            S_SCAN: begin
                if (scan.done) begin
                    res.page_found = scan.found;
                    res.page_index = scan.found ? page_to_idx(scan.page) : 3'd0;
                    finish         = 1'b1;
                end
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = r_fill_byte;
                n_addr    = r_addr + 1'b1;
                if (r_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                    // The pass after reset gives no result; a fill does.
                    n_fill_pending = 1'b0;
                    if (r_fill_pending) begin
                        finish = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is
        // free, and otherwise waits in the result holding register.
        if (finish) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out       = res;
                n_state     = S_IDLE;
            end else begin
                n_res   = res;
                n_state = S_RESP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_addr         <= '0;
            r_fill_byte    <= BYTE_ZERO;
            r_fill_pending <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_addr         <= n_addr;
            r_fill_byte    <= n_fill_byte;
            r_fill_pending <= n_fill_pending;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mask  <= n_mask;
        r_color <= n_color;
        r_page  <= n_page;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

    mpfd_ram #(
        .DATA_W (8),
        .ADDR_W (ADDR_W)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mpfd_dirty u_dirty (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dirty_cmd),
        .o_status (scan)
    );

endmodule

`default_nettype wire
